// ===== rtl/ets_pkg.sv =====
`default_nettype none

package ets_pkg;

    // field widths
    localparam int SECS_W   = 31;
    localparam int YEAR_W   = 11;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    // internal widths
    localparam int DAYS_W   = 15;   // whole days since base, up to 24855
    localparam int PC_W     = 4;    // microprogram address
    localparam int YLEN_W   = 9;    // 365 or 366
    localparam int PROD_W   = 49;   // widest reciprocal product, 24 by 25 bits

    // calendar constants
    localparam logic [YEAR_W-1:0]  BASE_YEAR = YEAR_W'(1970);
    localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);

    // constant divisors
    localparam logic [SECS_W-1:0] DAY_SECS  = SECS_W'(86400);
    localparam logic [SECS_W-1:0] HOUR_SECS = SECS_W'(3600);
    localparam logic [SECS_W-1:0] MIN_SECS  = SECS_W'(60);

    // reciprocal division: drop the power of two of the divisor, multiply by
    // the rounded-up reciprocal of the odd part, quotient starts at the shift
    // 86400 = 128 * 675, shifted dividend below 2^24
    localparam int DAY_X_LSB  = 7;
    localparam int DAY_X_W    = 24;
    localparam int DAY_SHIFT  = 34;
    localparam logic [PROD_W-1:0] RECIP_DAY  = PROD_W'(25451659);
    // 3600 = 16 * 225, shifted dividend below 2^13
    localparam int HOUR_X_LSB = 4;
    localparam int HOUR_X_W   = 13;
    localparam int HOUR_SHIFT = 21;
    localparam logic [PROD_W-1:0] RECIP_HOUR = PROD_W'(9321);
    // 60 = 4 * 15, shifted dividend below 2^10
    localparam int MIN_X_LSB  = 2;
    localparam int MIN_X_W    = 10;
    localparam int MIN_SHIFT  = 14;
    localparam logic [PROD_W-1:0] RECIP_MIN  = PROD_W'(1093);

    // micro-operations
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_MUL,
        OP_STORE,
        OP_YEAR,
        OP_MONTH,
        OP_OUT,
        OP_JMP
    } t_op;

    // which constant division a step works on
    typedef enum logic [1:0] {
        SEL_DAY,
        SEL_HOUR,
        SEL_MIN
    } t_dsel;

    // control word: on a true condition go to jmp, otherwise to the next step
    typedef struct packed {
        t_op             op;
        t_dsel           sel;
        logic [PC_W-1:0] jmp;
    } t_uword;

    // datapath controls from the sequencer
    typedef struct packed {
        t_op   op;
        t_dsel sel;
        logic  load;
    } t_dp_ctl;

    // datapath status back to the sequencer
    typedef struct packed {
        logic year_go;
        logic month_go;
    } t_dp_stat;

    // microprogram
    function automatic t_uword ucode(input logic [PC_W-1:0] addr);
        t_uword w;
        w = '{op: OP_JMP, sel: SEL_DAY, jmp: PC_W'(0)};
        unique case (addr)
            PC_W'(0):  w = '{op: OP_IDLE,  sel: SEL_DAY,  jmp: PC_W'(0)};
            PC_W'(1):  w = '{op: OP_MUL,   sel: SEL_DAY,  jmp: PC_W'(0)};
            PC_W'(2):  w = '{op: OP_STORE, sel: SEL_DAY,  jmp: PC_W'(0)};
            PC_W'(3):  w = '{op: OP_MUL,   sel: SEL_HOUR, jmp: PC_W'(0)};
            PC_W'(4):  w = '{op: OP_STORE, sel: SEL_HOUR, jmp: PC_W'(0)};
            PC_W'(5):  w = '{op: OP_MUL,   sel: SEL_MIN,  jmp: PC_W'(0)};
            PC_W'(6):  w = '{op: OP_STORE, sel: SEL_MIN,  jmp: PC_W'(0)};
            PC_W'(7):  w = '{op: OP_YEAR,  sel: SEL_DAY,  jmp: PC_W'(7)};
            PC_W'(8):  w = '{op: OP_MONTH, sel: SEL_DAY,  jmp: PC_W'(8)};
            PC_W'(9):  w = '{op: OP_OUT,   sel: SEL_DAY,  jmp: PC_W'(9)};
            PC_W'(10): w = '{op: OP_JMP,   sel: SEL_DAY,  jmp: PC_W'(0)};
            default:   w = '{op: OP_JMP,   sel: SEL_DAY,  jmp: PC_W'(0)};
        endcase
        return w;
    endfunction

    // month length, february by leap flag
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] d;
        d = DAY_W'(31);
        unique case (m)
            FEBRUARY:     d = leap ? DAY_W'(29) : DAY_W'(28);
            MONTH_W'(4),
            MONTH_W'(6),
            MONTH_W'(9),
            MONTH_W'(11): d = DAY_W'(30);
            default:      d = DAY_W'(31);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ets_if.sv =====
`default_nettype none

// seconds count channel
interface ets_secs_if;
    logic                         valid;
    logic                         ready;
    logic [ets_pkg::SECS_W-1:0]   epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// calendar result channel
interface ets_cal_if;
    logic                         valid;
    logic                         ready;
    logic [ets_pkg::YEAR_W-1:0]   year;
    logic [ets_pkg::MONTH_W-1:0]  month;
    logic [ets_pkg::DAY_W-1:0]    day_of_month;
    logic [ets_pkg::HOUR_W-1:0]   hour;
    logic [ets_pkg::MIN_W-1:0]    minute;
    logic [ets_pkg::SEC_W-1:0]    second;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

// ===== rtl/ets_datapath.sv =====
`default_nettype none

module ets_datapath (
    input  wire                            i_clk,
    input  wire ets_pkg::t_dp_ctl          i_ctl,
    input  wire [ets_pkg::SECS_W-1:0]      i_secs,
    output ets_pkg::t_dp_stat              o_stat,
    output logic [ets_pkg::YEAR_W-1:0]     o_year,
    output logic [ets_pkg::MONTH_W-1:0]    o_month,
    output logic [ets_pkg::DAY_W-1:0]      o_day_of_month,
    output logic [ets_pkg::HOUR_W-1:0]     o_hour,
    output logic [ets_pkg::MIN_W-1:0]      o_minute,
    output logic [ets_pkg::SEC_W-1:0]      o_second
);

    logic [ets_pkg::SECS_W-1:0]  r_acc;
    logic [ets_pkg::PROD_W-1:0]  r_prod;
    logic [ets_pkg::DAYS_W-1:0]  r_days;
    logic [ets_pkg::YEAR_W-1:0]  r_year;
    logic [ets_pkg::MONTH_W-1:0] r_month;
    logic [ets_pkg::HOUR_W-1:0]  r_hour;
    logic [ets_pkg::MIN_W-1:0]   r_min;
    logic [ets_pkg::SEC_W-1:0]   r_sec;

    logic                        leap;
    logic [ets_pkg::YLEN_W-1:0]  year_len;
    logic [ets_pkg::DAY_W-1:0]   mon_len;
    logic [ets_pkg::PROD_W-1:0]  prod;
    logic [ets_pkg::DAYS_W-1:0]  q_day;
    logic [ets_pkg::HOUR_W-1:0]  q_hour;
    logic [ets_pkg::MIN_W-1:0]   q_min;
    logic [ets_pkg::SECS_W-1:0]  q_back;
    logic [ets_pkg::SECS_W-1:0]  rem_secs;

    // calendar lengths for the current year and month
    always_comb begin
        leap     = (r_year[1:0] == 2'b00);
        year_len = leap ? ets_pkg::YLEN_W'(366) : ets_pkg::YLEN_W'(365);
        mon_len  = ets_pkg::days_in_month(r_month, leap);
    end

    // reciprocal product of the shifted dividend
    always_comb begin
        case (i_ctl.sel)
            ets_pkg::SEL_HOUR: begin
                prod = ets_pkg::PROD_W'(r_acc[ets_pkg::HOUR_X_LSB +: ets_pkg::HOUR_X_W])
                       * ets_pkg::RECIP_HOUR;
            end
            ets_pkg::SEL_MIN: begin
                prod = ets_pkg::PROD_W'(r_acc[ets_pkg::MIN_X_LSB +: ets_pkg::MIN_X_W])
                       * ets_pkg::RECIP_MIN;
            end
            default: begin
                prod = ets_pkg::PROD_W'(r_acc[ets_pkg::DAY_X_LSB +: ets_pkg::DAY_X_W])
                       * ets_pkg::RECIP_DAY;
            end
        endcase
    end

    // quotients from the registered product, remainder by back-multiplication
    always_comb begin
        q_day  = r_prod[ets_pkg::DAY_SHIFT +: ets_pkg::DAYS_W];
        q_hour = r_prod[ets_pkg::HOUR_SHIFT +: ets_pkg::HOUR_W];
        q_min  = r_prod[ets_pkg::MIN_SHIFT +: ets_pkg::MIN_W];
        case (i_ctl.sel)
            ets_pkg::SEL_HOUR: q_back = ets_pkg::SECS_W'(q_hour) * ets_pkg::HOUR_SECS;
            ets_pkg::SEL_MIN:  q_back = ets_pkg::SECS_W'(q_min) * ets_pkg::MIN_SECS;
            default:           q_back = ets_pkg::SECS_W'(q_day) * ets_pkg::DAY_SECS;
        endcase
        rem_secs = r_acc - q_back;
    end

    // loop conditions for the sequencer
    always_comb begin
        o_stat.year_go  = (r_days >= ets_pkg::DAYS_W'(year_len));
        o_stat.month_go = (r_month < ets_pkg::DECEMBER)
                          && (r_days >= ets_pkg::DAYS_W'(mon_len));
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ets_pkg::OP_IDLE: begin
                if (i_ctl.load) begin
                    r_acc   <= i_secs;
                    r_year  <= ets_pkg::BASE_YEAR;
                    r_month <= ets_pkg::JANUARY;
                end
            end
            ets_pkg::OP_MUL: begin
                r_prod <= prod;
            end
            // quotient out, remainder back into the accumulator
            ets_pkg::OP_STORE: begin
                r_acc <= rem_secs;
                case (i_ctl.sel)
                    ets_pkg::SEL_HOUR: r_hour <= q_hour;
                    ets_pkg::SEL_MIN: begin
                        r_min <= q_min;
                        r_sec <= rem_secs[ets_pkg::SEC_W-1:0];
                    end
                    default: r_days <= q_day;
                endcase
            end
            // strip one whole year
            ets_pkg::OP_YEAR: begin
                if (o_stat.year_go) begin
                    r_days <= r_days - ets_pkg::DAYS_W'(year_len);
                    r_year <= r_year + ets_pkg::YEAR_W'(1);
                end
            end
            // strip one whole month
            ets_pkg::OP_MONTH: begin
                if (o_stat.month_go) begin
                    r_days  <= r_days - ets_pkg::DAYS_W'(mon_len);
                    r_month <= r_month + ets_pkg::MONTH_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result fields
    always_comb begin
        o_year         = r_year;
        o_month        = r_month;
        o_day_of_month = r_days[ets_pkg::DAY_W-1:0] + ets_pkg::DAY_W'(1);
        o_hour         = r_hour;
        o_minute       = r_min;
        o_second       = r_sec;
    end

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar.sv =====
`default_nettype none

// Converts a count of seconds since 1970-01-01 00:00:00 into year, month, day
// of month, hour, minute and second. An 11-step microprogram in a constant table
// runs a small datapath: three constant divisions (by 86400, 3600 and 60) each
// made of a multiply by a fixed reciprocal and a store of quotient and remainder;
// then whole years are subtracted one per cycle from 1970 upward and whole months
// one per cycle. A finished result waits at the output step until the previous
// one leaves the output register; the year walk sets most of the time an item
// occupies the block. Items are handled one at a time; a new beat is taken once
// the previous result is in the output register, even if it is still waiting to
// be taken. Every year divisible by four counts as a leap year.

module epoch_seconds_to_calendar (
    input  wire  i_clk,
    input  wire  i_rst_n,
    ets_secs_if.sink   i_sec_in,
    ets_cal_if.source  o_cal_out
);

    logic [ets_pkg::PC_W-1:0]    r_pc;
    logic [ets_pkg::PC_W-1:0]    n_pc;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [ets_pkg::YEAR_W-1:0]  r_year;
    logic [ets_pkg::MONTH_W-1:0] r_month;
    logic [ets_pkg::DAY_W-1:0]   r_dom;
    logic [ets_pkg::HOUR_W-1:0]  r_hour;
    logic [ets_pkg::MIN_W-1:0]   r_min;
    logic [ets_pkg::SEC_W-1:0]   r_sec;

    ets_pkg::t_uword             uw;
    ets_pkg::t_dp_ctl            dp_ctl;
    ets_pkg::t_dp_stat           dp_stat;
    logic                        take_jmp;
    logic                        out_busy;
    logic                        out_load;

    logic [ets_pkg::YEAR_W-1:0]  dp_year;
    logic [ets_pkg::MONTH_W-1:0] dp_month;
    logic [ets_pkg::DAY_W-1:0]   dp_dom;
    logic [ets_pkg::HOUR_W-1:0]  dp_hour;
    logic [ets_pkg::MIN_W-1:0]   dp_min;
    logic [ets_pkg::SEC_W-1:0]   dp_sec;

    // sequencer: fetch, branch condition, next step
    always_comb begin
        uw         = ets_pkg::ucode(r_pc);
        out_busy   = r_out_valid && !o_cal_out.ready;
        out_load   = 1'b0;
        take_jmp   = 1'b0;
        dp_ctl.op  = uw.op;
        dp_ctl.sel = uw.sel;
        dp_ctl.load = (uw.op == ets_pkg::OP_IDLE) && i_sec_in.valid;
        unique case (uw.op)
            ets_pkg::OP_IDLE:     take_jmp = !i_sec_in.valid;
            ets_pkg::OP_YEAR:     take_jmp = dp_stat.year_go;
            ets_pkg::OP_MONTH:    take_jmp = dp_stat.month_go;
            ets_pkg::OP_OUT: begin
                take_jmp = out_busy;
                out_load = !out_busy;
            end
            ets_pkg::OP_JMP:      take_jmp = 1'b1;
            default:              take_jmp = 1'b0;
        endcase
        n_pc = take_jmp ? uw.jmp : r_pc + ets_pkg::PC_W'(1);

        // output valid flag
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_cal_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_year  <= dp_year;
            r_month <= dp_month;
            r_dom   <= dp_dom;
            r_hour  <= dp_hour;
            r_min   <= dp_min;
            r_sec   <= dp_sec;
        end
    end

    ets_datapath u_dp (
        .i_clk          (i_clk),
        .i_ctl          (dp_ctl),
        .i_secs         (i_sec_in.epoch_seconds),
        .o_stat         (dp_stat),
        .o_year         (dp_year),
        .o_month        (dp_month),
        .o_day_of_month (dp_dom),
        .o_hour         (dp_hour),
        .o_minute       (dp_min),
        .o_second       (dp_sec)
    );

    // channel ports
    assign i_sec_in.ready         = (uw.op == ets_pkg::OP_IDLE);
    assign o_cal_out.valid        = r_out_valid;
    assign o_cal_out.year         = r_year;
    assign o_cal_out.month        = r_month;
    assign o_cal_out.day_of_month = r_dom;
    assign o_cal_out.hour         = r_hour;
    assign o_cal_out.minute       = r_min;
    assign o_cal_out.second       = r_sec;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int SECS_W  = ets_pkg::SECS_W;
    localparam int YEAR_W  = ets_pkg::YEAR_W;
    localparam int MONTH_W = ets_pkg::MONTH_W;
    localparam int DAY_W   = ets_pkg::DAY_W;
    localparam int HOUR_W  = ets_pkg::HOUR_W;
    localparam int MIN_W   = ets_pkg::MIN_W;
    localparam int SEC_W   = ets_pkg::SEC_W;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned FIRST_YEAR    = 1970;
    localparam int unsigned LAST_FULL_YEAR = 2037;
    localparam int          RANDOM_ITEMS  = 880;
    localparam int          QUIET_TAIL    = 60;     // items at the end sent with no idling
    localparam int          STALL_LIMIT   = 4000;   // cycles with no beat on either side
    localparam int          SETTLE_CYCLES = 150;
    localparam int          PRINT_LIMIT   = 60;

    // one seconds count and whether to hold it until the result store is empty
    typedef struct {
        logic [SECS_W-1:0] secs;
        bit                drain_first;
    } t_secs_item;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_calendar;

    logic i_clk;
    logic i_rst_n;

    ets_secs_if sec_if ();
    ets_cal_if  cal_if ();

    epoch_seconds_to_calendar u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sec_in  (sec_if),
        .o_cal_out (cal_if)
    );

    t_secs_item secs_queue[$];
    t_calendar  calendar_expected[$];
    int         error_count    = 0;
    int         sent_total     = 0;
    int         accepted_count = 0;
    int         result_count   = 0;
    int         quiet_cycles   = 0;
    bit         sec_beat_taken = 1'b0;
    int         send_gap       = 0;
    int         stall_left     = 0;
    int         calm_left      = 0;

    // leap rule as the block has it: every fourth year is a leap year
    function automatic bit leap_year(input int unsigned y);
        return (y % 4) == 0;
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y)) begin
            return 29;
        end
        return lengths[(m - 1) % 12];
    endfunction

    // days from the base date to the first of the given month
    function automatic int unsigned days_to_month(input int unsigned y, input int unsigned m);
        int unsigned d;
        d = 0;
        for (int unsigned yy = FIRST_YEAR; yy < y; yy++) begin
            d += leap_year(yy) ? 366 : 365;
        end
        for (int unsigned mm = 1; mm < m; mm++) begin
            d += month_length(mm, y);
        end
        return d;
    endfunction

    // calendar date and time of day for a seconds count
    function automatic t_calendar calendar_of(input logic [SECS_W-1:0] secs);
        t_calendar   c;
        int unsigned total;
        int unsigned days;
        int unsigned sod;
        int unsigned y;
        int unsigned m;
        total = secs;
        days = total / SECS_PER_DAY;
        sod = total % SECS_PER_DAY;
        c.hour = HOUR_W'(sod / SECS_PER_HOUR);
        c.minute = MIN_W'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
        c.second = SEC_W'(sod % SECS_PER_MIN);
        y = FIRST_YEAR;
        while (days >= (leap_year(y) ? 366 : 365)) begin
            days -= leap_year(y) ? 366 : 365;
            y++;
        end
        m = 1;
        while (m < 12 && days >= month_length(m, y)) begin
            days -= month_length(m, y);
            m++;
        end
        c.year = YEAR_W'(y);
        c.month = MONTH_W'(m);
        c.day_of_month = DAY_W'(days + 1);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic push_secs(input logic [SECS_W-1:0] secs, input bit drain_first);
        t_secs_item it;
        it.secs = secs;
        it.drain_first = drain_first;
        secs_queue.push_back(it);
        sent_total++;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // reset
    initial begin
        i_rst_n = 1'b0;
        sec_if.valid = 1'b0;
        sec_if.epoch_seconds = '0;
        cal_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // seconds driver, changes at the falling edge
    always @(negedge i_clk) begin
        t_secs_item it;
        bit quiet;
        quiet = secs_queue.size() < QUIET_TAIL;
        if (!i_rst_n) begin
            sec_if.valid <= 1'b0;
        end else if (!sec_if.valid || sec_beat_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                sec_if.valid <= 1'b0;
            end else if (secs_queue.size() > 0 &&
                         !(secs_queue[0].drain_first && calendar_expected.size() > 0)) begin
                it = secs_queue.pop_front();
                sec_if.valid <= 1'b1;
                sec_if.epoch_seconds <= it.secs;
                // idle bursts between beats, with calm stretches in between
                if (calm_left > 0) begin
                    calm_left--;
                end else if (!quiet && $urandom_range(15) == 0) begin
                    calm_left = $urandom_range(40, 10);
                end else if (!quiet && $urandom_range(2) == 0) begin
                    send_gap = $urandom_range(13, 1);
                end
            end else begin
                sec_if.valid <= 1'b0;
            end
        end
    end

    // result ready, stalls in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cal_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            cal_if.ready <= 1'b0;
        end else if (secs_queue.size() >= QUIET_TAIL && calm_left == 0 &&
                     $urandom_range(7) == 0) begin
            stall_left = $urandom_range(13, 1) - 1;
            cal_if.ready <= 1'b0;
        end else begin
            cal_if.ready <= 1'b1;
        end
    end

    // monitor: predict on each input beat, check each result beat
    always @(posedge i_clk) begin
        t_calendar want;
        bit any_beat;
        any_beat = 1'b0;
        sec_beat_taken = 1'b0;
        if (i_rst_n) begin
            if (sec_if.valid && sec_if.ready) begin
                sec_beat_taken = 1'b1;
                any_beat = 1'b1;
                accepted_count++;
                calendar_expected.push_back(calendar_of(sec_if.epoch_seconds));
            end
            if (cal_if.valid && cal_if.ready) begin
                any_beat = 1'b1;
                result_count++;
                if (calendar_expected.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = calendar_expected.pop_front();
                    check_field("year", cal_if.year, want.year);
                    check_field("month", cal_if.month, want.month);
                    check_field("day_of_month", cal_if.day_of_month, want.day_of_month);
                    check_field("hour", cal_if.hour, want.hour);
                    check_field("minute", cal_if.minute, want.minute);
                    check_field("second", cal_if.second, want.second);
                end
            end
            // watchdog
            quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] no beat for %0d cycles", $realtime, STALL_LIMIT);
                $display("epoch_seconds_to_calendar regression: fail");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned kind;
        logic [SECS_W-1:0] secs;

        // field extremes and the units of the time of day
        push_secs(SECS_W'(0), 1'b0);
        push_secs({SECS_W{1'b1}}, 1'b0);
        push_secs(SECS_W'(59), 1'b0);
        push_secs(SECS_W'(60), 1'b0);
        push_secs(SECS_W'(3599), 1'b0);
        push_secs(SECS_W'(3600), 1'b0);
        push_secs(SECS_W'(86399), 1'b0);
        push_secs(SECS_W'(86400), 1'b0);
        // month and year turnovers, leap february
        push_secs(SECS_W'(days_to_month(1970, 2) * SECS_PER_DAY - 1), 1'b0);
        push_secs(SECS_W'(days_to_month(1970, 2) * SECS_PER_DAY), 1'b0);
        push_secs(SECS_W'(days_to_month(1971, 3) * SECS_PER_DAY - 1), 1'b0);
        push_secs(SECS_W'(days_to_month(1972, 3) * SECS_PER_DAY - 1), 1'b0);
        push_secs(SECS_W'(days_to_month(1972, 3) * SECS_PER_DAY), 1'b0);
        push_secs(SECS_W'(days_to_month(1973, 1) * SECS_PER_DAY - 1), 1'b0);
        push_secs(SECS_W'(days_to_month(1973, 1) * SECS_PER_DAY), 1'b0);
        push_secs(SECS_W'(days_to_month(2000, 3) * SECS_PER_DAY - 1), 1'b0);
        push_secs(SECS_W'(days_to_month(2000, 1) * SECS_PER_DAY), 1'b0);
        push_secs(SECS_W'(days_to_month(2038, 1) * SECS_PER_DAY - 1), 1'b0);
        push_secs(SECS_W'(days_to_month(2038, 1) * SECS_PER_DAY), 1'b0);
        // alternating and single-bit patterns
        push_secs(SECS_W'(32'h5555_5555), 1'b0);
        push_secs(SECS_W'(32'h2AAA_AAAA), 1'b0);
        push_secs(SECS_W'(32'h4000_0000), 1'b0);
        push_secs(SECS_W'(1), 1'b0);

        // random part: uniform counts mixed with counts close to day, month and year edges
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                secs = SECS_W'($urandom);
            end else if (kind < 7) begin
                d = $urandom_range(24854);
                case ($urandom_range(2))
                    0: secs = SECS_W'(d * SECS_PER_DAY);
                    1: secs = SECS_W'(d * SECS_PER_DAY + SECS_PER_DAY - 1);
                    default: secs = SECS_W'(d * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1));
                endcase
            end else begin
                y = $urandom_range(LAST_FULL_YEAR, FIRST_YEAR);
                m = $urandom_range(12, 1);
                d = days_to_month(y, m);
                case ($urandom_range(2))
                    0: secs = SECS_W'(d * SECS_PER_DAY - 1);
                    1: secs = SECS_W'(d * SECS_PER_DAY);
                    default: secs = SECS_W'(d * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1));
                endcase
            end
            push_secs(secs, i == 0 || $urandom_range(99) == 0);
        end

        wait (i_rst_n);
        while (accepted_count < sent_total || result_count < accepted_count) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && calendar_expected.size() == 0) begin
            $display("epoch_seconds_to_calendar regression: pass");
        end else begin
            $display("epoch_seconds_to_calendar regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ets_pkg.sv
rtl/ets_if.sv
rtl/ets_datapath.sv
rtl/epoch_seconds_to_calendar.sv
sim/testbench.sv
